// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsoc_pkg.sv =====
`timescale 1ns / 1ps

package lsoc_pkg;

  localparam int DEF_OFFSET_BITS  = 32;
  localparam int DEF_COUNT_BITS   = 32;
  localparam int DEF_STAMP_DIGITS = 10;

  localparam int THRESH_BITS = 32;
  localparam int SUM_BITS    = 48;

  localparam logic [THRESH_BITS-1:0] GAP_RESET = 32'd4096;
  localparam logic [SUM_BITS-1:0]    SUM_LIMIT = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,
    CLS_ORDER = 2'd1,
    CLS_BACK  = 2'd2,
    CLS_GAP   = 2'd3
  } class_t;

  typedef struct packed {
    logic [33:0]         stamp;
    class_t              record_class;
    logic [33:0]         distance;
    logic [31:0]         record_offset;
    logic [31:0]         max_offset;
    logic [33:0]         max_stamp;
    logic [33:0]         first_stamp;
    logic [31:0]         record_total;
    logic [31:0]         backward_total;
    logic [31:0]         gap_total;
    logic [SUM_BITS-1:0] gap_byte_total;
  } result_t;

  // Bits needed to hold the largest stamp of the given digit count.
  function automatic int stamp_bits(input int digits);
    logic [63:0] p;
    int          b;
    p = 64'd1;
    b = 1;
    for (int i = 0; i < digits; i++) begin
      p = p * 64'd10;
    end
    p = p - 64'd1;
    for (int i = 0; i < 64; i++) begin
      if (p[i]) begin
        b = i + 1;
      end
    end
    return b;
  endfunction

endpackage

// ===== sv/lsoc_parse.sv =====
`timescale 1ns / 1ps

module lsoc_parse #(
  parameter int OFFSET_BITS  = lsoc_pkg::DEF_OFFSET_BITS,
  parameter int STAMP_DIGITS = lsoc_pkg::DEF_STAMP_DIGITS,
  parameter int STAMP_BITS   = lsoc_pkg::stamp_bits(STAMP_DIGITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             data_byte,
  input  logic                   file_first,
  output logic                   hit,
  output logic [STAMP_BITS-1:0]  stamp_val,
  output logic [OFFSET_BITS-1:0] rec_offset
);

  localparam int MPW = $clog2(STAMP_DIGITS + 2);

  logic                   line_start;
  logic [MPW-1:0]         match_position;
  logic [STAMP_BITS-1:0]  digit_accumulator;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] bracket_position;

  logic                   line_start_next;
  logic [MPW-1:0]         match_position_next;
  logic [STAMP_BITS-1:0]  digit_accumulator_next;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [OFFSET_BITS-1:0] bracket_position_next;

  logic                   ls_eff;
  logic [MPW-1:0]         mp_eff;
  logic [STAMP_BITS-1:0]  acc_eff;
  logic [OFFSET_BITS-1:0] bp_eff;
  logic [OFFSET_BITS-1:0] brk_eff;
  logic [7:0]             digit;
  logic                   is_digit;

  always_comb begin
    // A new file starts from cleared state before its first byte is looked at.
    ls_eff   = file_first ? 1'b1 : line_start;
    mp_eff   = file_first ? '0 : match_position;
    acc_eff  = file_first ? '0 : digit_accumulator;
    bp_eff   = file_first ? '0 : byte_position;
    brk_eff  = file_first ? '0 : bracket_position;
    digit    = data_byte - lsoc_pkg::CHAR_ZERO;
    is_digit = (data_byte >= lsoc_pkg::CHAR_ZERO) && (data_byte <= lsoc_pkg::CHAR_NINE);

    match_position_next    = mp_eff;
    digit_accumulator_next = acc_eff;
    bracket_position_next  = brk_eff;
    hit                    = 1'b0;

    if (mp_eff == '0) begin
      if ((data_byte == lsoc_pkg::CHAR_OPEN) && ls_eff) begin
        match_position_next    = MPW'(1);
        digit_accumulator_next = '0;
        bracket_position_next  = bp_eff;
      end
    end else if (mp_eff <= MPW'(STAMP_DIGITS)) begin
      if (is_digit) begin
        digit_accumulator_next = (acc_eff << 3) + (acc_eff << 1)
                                 + STAMP_BITS'(digit[3:0]);
        match_position_next    = mp_eff + MPW'(1);
      end else begin
        match_position_next = '0;
      end
    end else begin
      match_position_next = '0;
      hit                 = (data_byte == lsoc_pkg::CHAR_CLOSE);
    end

    line_start_next    = (data_byte == lsoc_pkg::CHAR_NL);
    byte_position_next = bp_eff + OFFSET_BITS'(1);
    stamp_val          = acc_eff;
    rec_offset         = brk_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_start        <= 1'b1;
      match_position    <= '0;
      digit_accumulator <= '0;
      byte_position     <= '0;
      bracket_position  <= '0;
    end else if (advance) begin
      line_start        <= line_start_next;
      match_position    <= match_position_next;
      digit_accumulator <= digit_accumulator_next;
      byte_position     <= byte_position_next;
      bracket_position  <= bracket_position_next;
    end
  end

endmodule

// ===== sv/lsoc_track.sv =====
`timescale 1ns / 1ps

module lsoc_track #(
  parameter int OFFSET_BITS  = lsoc_pkg::DEF_OFFSET_BITS,
  parameter int COUNT_BITS   = lsoc_pkg::DEF_COUNT_BITS,
  parameter int STAMP_BITS   = lsoc_pkg::stamp_bits(lsoc_pkg::DEF_STAMP_DIGITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               file_first,
  input  logic                               hit,
  input  logic [STAMP_BITS-1:0]              stamp_val,
  input  logic [OFFSET_BITS-1:0]             rec_offset,
  input  logic [lsoc_pkg::THRESH_BITS-1:0]   gap_threshold,
  output lsoc_pkg::result_t                  result
);

  localparam int SB = lsoc_pkg::SUM_BITS;

  logic                   seen_first;
  logic [STAMP_BITS-1:0]  running_maximum;
  logic [OFFSET_BITS-1:0] maximum_position;
  logic [STAMP_BITS-1:0]  opening_stamp;
  logic [COUNT_BITS-1:0]  record_counter;
  logic [COUNT_BITS-1:0]  backward_counter;
  logic [COUNT_BITS-1:0]  gap_counter;
  logic [SB-1:0]          gap_byte_sum;

  logic                   seen_first_next;
  logic [STAMP_BITS-1:0]  running_maximum_next;
  logic [OFFSET_BITS-1:0] maximum_position_next;
  logic [STAMP_BITS-1:0]  opening_stamp_next;
  logic [COUNT_BITS-1:0]  record_counter_next;
  logic [COUNT_BITS-1:0]  backward_counter_next;
  logic [COUNT_BITS-1:0]  gap_counter_next;
  logic [SB-1:0]          gap_byte_sum_next;

  logic                   seen_eff;
  logic [STAMP_BITS-1:0]  max_eff;
  logic [OFFSET_BITS-1:0] mpos_eff;
  logic [STAMP_BITS-1:0]  open_eff;
  logic [COUNT_BITS-1:0]  rc_eff;
  logic [COUNT_BITS-1:0]  bc_eff;
  logic [COUNT_BITS-1:0]  gc_eff;
  logic [SB-1:0]          sum_eff;

  logic                   below;
  logic                   is_gap;
  logic [STAMP_BITS-1:0]  span;
  logic [64:0]            sum_wide;
  lsoc_pkg::class_t       cls;

  always_comb begin
    seen_eff = file_first ? 1'b0 : seen_first;
    max_eff  = file_first ? '0 : running_maximum;
    mpos_eff = file_first ? '0 : maximum_position;
    open_eff = file_first ? '0 : opening_stamp;
    rc_eff   = file_first ? '0 : record_counter;
    bc_eff   = file_first ? '0 : backward_counter;
    gc_eff   = file_first ? '0 : gap_counter;
    sum_eff  = file_first ? '0 : gap_byte_sum;

    below    = stamp_val < max_eff;
    span     = below ? (max_eff - stamp_val) : (stamp_val - max_eff);
    is_gap   = !below && (64'(span) > 64'(gap_threshold));
    sum_wide = 65'(sum_eff) + 65'(span);

    seen_first_next       = seen_eff;
    running_maximum_next  = max_eff;
    maximum_position_next = mpos_eff;
    opening_stamp_next    = open_eff;
    record_counter_next   = rc_eff;
    backward_counter_next = bc_eff;
    gap_counter_next      = gc_eff;
    gap_byte_sum_next     = sum_eff;

    if (!seen_eff) begin
      cls = lsoc_pkg::CLS_FIRST;
    end else if (below) begin
      cls = lsoc_pkg::CLS_BACK;
    end else if (is_gap) begin
      cls = lsoc_pkg::CLS_GAP;
    end else begin
      cls = lsoc_pkg::CLS_ORDER;
    end

    if (hit) begin
      seen_first_next     = 1'b1;
      record_counter_next = (&rc_eff) ? rc_eff : rc_eff + COUNT_BITS'(1);
      if (!seen_eff) begin
        opening_stamp_next = stamp_val;
      end
      if (cls == lsoc_pkg::CLS_BACK) begin
        backward_counter_next = (&bc_eff) ? bc_eff : bc_eff + COUNT_BITS'(1);
      end
      if (cls == lsoc_pkg::CLS_GAP) begin
        gap_counter_next  = (&gc_eff) ? gc_eff : gc_eff + COUNT_BITS'(1);
        gap_byte_sum_next = (sum_wide >= 65'(lsoc_pkg::SUM_LIMIT)) ?
                            lsoc_pkg::SUM_LIMIT : sum_wide[SB-1:0];
      end
      // An equal stamp also takes over the maximum and its offset.
      if (!below) begin
        running_maximum_next  = stamp_val;
        maximum_position_next = rec_offset;
      end
    end

    result.stamp          = 34'(stamp_val);
    result.record_class   = cls;
    result.distance       = seen_eff ? 34'(span) : 34'd0;
    result.record_offset  = 32'(rec_offset);
    result.max_offset     = 32'(mpos_eff);
    result.max_stamp      = 34'(max_eff);
    result.first_stamp    = 34'(opening_stamp_next);
    result.record_total   = 32'(record_counter_next);
    result.backward_total = 32'(backward_counter_next);
    result.gap_total      = 32'(gap_counter_next);
    result.gap_byte_total = gap_byte_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first       <= 1'b0;
      running_maximum  <= '0;
      maximum_position <= '0;
      opening_stamp    <= '0;
      record_counter   <= '0;
      backward_counter <= '0;
      gap_counter      <= '0;
      gap_byte_sum     <= '0;
    end else if (advance) begin
      seen_first       <= seen_first_next;
      running_maximum  <= running_maximum_next;
      maximum_position <= maximum_position_next;
      opening_stamp    <= opening_stamp_next;
      record_counter   <= record_counter_next;
      backward_counter <= backward_counter_next;
      gap_counter      <= gap_counter_next;
      gap_byte_sum     <= gap_byte_sum_next;
    end
  end

endmodule

// ===== sv/log_stamp_order_checker.sv =====
// A transferred byte is held in the input register, and its result in the output register.
// Throughput: one byte per cycle while no result waits on out_ready; the input register and
//   the output register form a two-stage pipeline and each byte is handled in a single pass
//   against the per-file state.
// Reset: synchronous rst empties both stages, clears all per-file state and loads the gap
//   threshold with 4096.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module log_stamp_order_checker #(
  parameter int OFFSET_BITS  = lsoc_pkg::DEF_OFFSET_BITS,
  parameter int COUNT_BITS   = lsoc_pkg::DEF_COUNT_BITS,
  parameter int STAMP_DIGITS = lsoc_pkg::DEF_STAMP_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        file_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [33:0] stamp,
  output logic [1:0]  record_class,
  output logic [33:0] distance,
  output logic [31:0] record_offset,
  output logic [31:0] max_offset,
  output logic [33:0] max_stamp,
  output logic [33:0] first_stamp,
  output logic [31:0] record_total,
  output logic [31:0] backward_total,
  output logic [31:0] gap_total,
  output logic [47:0] gap_byte_total
);

  localparam int STAMP_BITS = lsoc_pkg::stamp_bits(STAMP_DIGITS);

  logic [lsoc_pkg::THRESH_BITS-1:0] gap_threshold;

  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_first;
  logic                   advance;

  logic                   hit;
  logic [STAMP_BITS-1:0]  stamp_val;
  logic [OFFSET_BITS-1:0] rec_offset;
  lsoc_pkg::result_t      result;
  lsoc_pkg::result_t      res_q;

  // Process the held byte only when the output register is free to take its result.
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= lsoc_pkg::GAP_RESET;
    end else if (cfg_write) begin
      gap_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte  <= data_byte;
      in_q_first <= file_first;
    end
  end

  lsoc_parse #(
    .OFFSET_BITS  (OFFSET_BITS),
    .STAMP_DIGITS (STAMP_DIGITS),
    .STAMP_BITS   (STAMP_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (in_q_byte),
    .file_first (in_q_first),
    .hit        (hit),
    .stamp_val  (stamp_val),
    .rec_offset (rec_offset)
  );

  lsoc_track #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .file_first    (in_q_first),
    .hit           (hit),
    .stamp_val     (stamp_val),
    .rec_offset    (rec_offset),
    .gap_threshold (gap_threshold),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      res_q <= result;
    end
  end

  assign stamp          = res_q.stamp;
  assign record_class   = res_q.record_class;
  assign distance       = res_q.distance;
  assign record_offset  = res_q.record_offset;
  assign max_offset     = res_q.max_offset;
  assign max_stamp      = res_q.max_stamp;
  assign first_stamp    = res_q.first_stamp;
  assign record_total   = res_q.record_total;
  assign backward_total = res_q.backward_total;
  assign gap_total      = res_q.gap_total;
  assign gap_byte_total = res_q.gap_byte_total;

  `CHK_NOW(a_first_zero, out_valid && (res_q.record_class == lsoc_pkg::CLS_FIRST),
           (distance == 34'd0) && (max_stamp == 34'd0) && (first_stamp == stamp),
           "first record must carry zero distance and its own stamp")
  `CHK_NOW(a_back_below, out_valid && (res_q.record_class == lsoc_pkg::CLS_BACK),
           (stamp < max_stamp) && (distance == max_stamp - stamp),
           "backward record must lie below the running maximum")
  `CHK_NOW(a_gap_above, out_valid && (res_q.record_class == lsoc_pkg::CLS_GAP),
           (distance != 34'd0) && (gap_byte_total != 48'd0) && (gap_total != 32'd0),
           "gap record must advance and be counted")
  `CHK_NEXT(a_result_hold, out_valid && !out_ready && !rst,
            out_valid && $stable(res_q),
            "pipeline must stall while a result waits")

endmodule

// ===== dv/log_stamp_order_checker_test.sv =====
`timescale 1ns / 1ps

module log_stamp_order_checker_test;
  import lsoc_pkg::*;

  localparam longint unsigned STAMP_MAX   = 64'd9999999999;
  localparam int              PHASE_BYTES = 325;
  localparam longint          CYCLE_LIMIT = 400000;

  // Per-file stamp order tracker; predicts one record per closing bracket that ends a complete stamp at a line start.
  class stamp_scoreboard;
    logic [31:0] gap_limit;
    bit          at_line_start;
    int unsigned digit_pos;
    logic [33:0] digits_val;
    logic [31:0] byte_pos;
    logic [31:0] open_pos;
    bit          seen_record;
    logic [33:0] top_stamp;
    logic [31:0] top_pos;
    logic [33:0] first_val;
    logic [31:0] rec_cnt;
    logic [31:0] back_cnt;
    logic [31:0] gap_cnt;
    logic [47:0] gap_sum;
    result_t     pending_records[$];
    int          errors;

    function new();
      gap_limit = GAP_RESET;
      errors = 0;
      restart_file();
    endfunction

    function void restart_file();
      at_line_start = 1'b1;
      digit_pos = 0;
      digits_val = '0;
      byte_pos = '0;
      open_pos = '0;
      seen_record = 1'b0;
      top_stamp = '0;
      top_pos = '0;
      first_val = '0;
      rec_cnt = '0;
      back_cnt = '0;
      gap_cnt = '0;
      gap_sum = '0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void note_byte(logic [7:0] b, logic ff);
      result_t     r;
      logic [33:0] prev_top;
      logic [31:0] prev_pos;
      logic [33:0] delta;
      class_t      cls;
      if (ff) restart_file();
      if (digit_pos == 0) begin
        if (b == CHAR_OPEN && at_line_start) begin
          digit_pos = 1;
          digits_val = '0;
          open_pos = byte_pos;
        end
      end else if (digit_pos <= DEF_STAMP_DIGITS) begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          digits_val = digits_val * 34'd10 + 34'(b - CHAR_ZERO);
          digit_pos++;
        end else begin
          digit_pos = 0;
        end
      end else begin
        digit_pos = 0;
        if (b == CHAR_CLOSE) begin
          prev_top = top_stamp;
          prev_pos = top_pos;
          delta = '0;
          rec_cnt = bump(rec_cnt);
          if (!seen_record) begin
            cls = CLS_FIRST;
            first_val = digits_val;
            seen_record = 1'b1;
          end else if (digits_val < prev_top) begin
            cls = CLS_BACK;
            delta = prev_top - digits_val;
            back_cnt = bump(back_cnt);
          end else begin
            delta = digits_val - prev_top;
            if (delta > {2'b00, gap_limit}) begin
              cls = CLS_GAP;
              gap_cnt = bump(gap_cnt);
              // saturate the running gap sum
              if ({14'd0, delta} >= SUM_LIMIT - gap_sum) gap_sum = SUM_LIMIT;
              else gap_sum = gap_sum + {14'd0, delta};
            end else begin
              cls = CLS_ORDER;
            end
          end
          // an equal stamp also takes over as the maximum
          if (digits_val >= prev_top) begin
            top_stamp = digits_val;
            top_pos = open_pos;
          end
          r.stamp = digits_val;
          r.record_class = cls;
          r.distance = delta;
          r.record_offset = open_pos;
          r.max_offset = prev_pos;
          r.max_stamp = prev_top;
          r.first_stamp = first_val;
          r.record_total = rec_cnt;
          r.backward_total = back_cnt;
          r.gap_total = gap_cnt;
          r.gap_byte_total = gap_sum;
          pending_records.push_back(r);
        end
      end
      at_line_start = (b == CHAR_NL);
      byte_pos = byte_pos + 32'd1;
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_record(result_t got);
      result_t want;
      if (pending_records.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected record, expected none, actual stamp %0d",
                   $time, got.stamp);
        return;
      end
      want = pending_records.pop_front();
      check_field("stamp", want.stamp, got.stamp);
      check_field("record_class", want.record_class, got.record_class);
      check_field("distance", want.distance, got.distance);
      check_field("record_offset", want.record_offset, got.record_offset);
      check_field("max_offset", want.max_offset, got.max_offset);
      check_field("max_stamp", want.max_stamp, got.max_stamp);
      check_field("first_stamp", want.first_stamp, got.first_stamp);
      check_field("record_total", want.record_total, got.record_total);
      check_field("backward_total", want.backward_total, got.backward_total);
      check_field("gap_total", want.gap_total, got.gap_total);
      check_field("gap_byte_total", want.gap_byte_total, got.gap_byte_total);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        file_first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [33:0] stamp;
  logic [1:0]  record_class;
  logic [33:0] distance;
  logic [31:0] record_offset;
  logic [31:0] max_offset;
  logic [33:0] max_stamp;
  logic [33:0] first_stamp;
  logic [31:0] record_total;
  logic [31:0] backward_total;
  logic [31:0] gap_total;
  logic [47:0] gap_byte_total;

  stamp_scoreboard sb = new();
  bit              sender_idles = 1'b1;
  bit              sink_idles = 1'b1;
  int              stall_left = 0;
  int              bytes_sent = 0;
  longint          cycle_count = 0;

  log_stamp_order_checker u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .file_first     (file_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stamp          (stamp),
    .record_class   (record_class),
    .distance       (distance),
    .record_offset  (record_offset),
    .max_offset     (max_offset),
    .max_stamp      (max_stamp),
    .first_stamp    (first_stamp),
    .record_total   (record_total),
    .backward_total (backward_total),
    .gap_total      (gap_total),
    .gap_byte_total (gap_byte_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.stamp = stamp;
      got.record_class = class_t'(record_class);
      got.distance = distance;
      got.record_offset = record_offset;
      got.max_offset = max_offset;
      got.max_stamp = max_stamp;
      got.first_stamp = first_stamp;
      got.record_total = record_total;
      got.backward_total = backward_total;
      got.gap_total = gap_total;
      got.gap_byte_total = gap_byte_total;
      sb.check_record(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic ff);
    if (sender_idles && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    file_first <= ff;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, ff);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_record(input logic [33:0] v, input logic ff);
    logic [7:0]      txt[DEF_STAMP_DIGITS];
    longint unsigned rest;
    rest = v;
    for (int i = DEF_STAMP_DIGITS - 1; i >= 0; i--) begin
      txt[i] = CHAR_ZERO + 8'(rest % 10);
      rest = rest / 10;
    end
    send_byte(CHAR_OPEN, ff);
    for (int i = 0; i < DEF_STAMP_DIGITS; i++) send_byte(txt[i], 1'b0);
    send_byte(CHAR_CLOSE, 1'b0);
  endtask

  // Hold off input until every record is out, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [31:0] v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.gap_limit = v;
  endtask

  initial begin
    longint unsigned top;
    longint unsigned lim;
    longint unsigned pick;
    int              kind;
    int              n;
    int              target;
    logic            ff;
    logic [7:0]      b;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lowest and highest stamps with no file start flag: first, then a gap.
    send_record(34'd0, 1'b0);
    send_byte(CHAR_NL, 1'b0);
    send_record(STAMP_MAX[33:0], 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_threshold(32'd0);
        1: set_threshold(32'hFFFF_FFFF);
        2: set_threshold(32'($urandom_range(1, 100000)));
        3: set_threshold(GAP_RESET);
        default: set_threshold($urandom);
      endcase
      if (ph == 4) begin
        sender_idles = 1'b0;
        sink_idles = 1'b0;
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if (ph < 4 && $urandom_range(0, 15) == 0) sender_idles = !sender_idles;
        if (ph < 4 && $urandom_range(0, 15) == 0) sink_idles = !sink_idles;
        ff = ($urandom_range(0, 11) == 0);
        top = sb.top_stamp;
        lim = sb.gap_limit;
        case ($urandom_range(0, 9))
          0: pick = top;
          1: pick = top + $urandom_range(1, 50);
          2: pick = top + lim;
          3: pick = top + lim + 1;
          4: pick = top + (longint'($urandom) << $urandom_range(0, 2));
          5: pick = (top > 1000) ? top - $urandom_range(1, 1000) : 0;
          6: pick = {$urandom, $urandom} % (STAMP_MAX + 1);
          7: pick = 0;
          8: pick = STAMP_MAX;
          default: pick = top + $urandom_range(0, 8192);
        endcase
        if (pick > STAMP_MAX) pick = STAMP_MAX;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
          send_record(pick[33:0], ff);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(32, 126)), 1'b0);
          send_byte(CHAR_NL, 1'b0);
        end else if (kind < 16) begin
          // broken prefix: cut short by a wrong byte, sometimes a newline
          send_byte(CHAR_OPEN, ff);
          n = $urandom_range(0, DEF_STAMP_DIGITS);
          repeat (n) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
          if ($urandom_range(0, 3) == 0) begin
            b = CHAR_NL;
          end else if (n < DEF_STAMP_DIGITS) begin
            do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_CLOSE);
          end
          send_byte(b, $urandom_range(0, 7) == 0);
          if (b != CHAR_NL) send_byte(CHAR_NL, 1'b0);
        end else if (kind < 19) begin
          n = $urandom_range(1, 10);
          send_byte(8'($urandom_range(0, 255)), ff);
          repeat (n - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(CHAR_NL, 1'b0);
        end else begin
          // record not at a line start: ignored
          send_byte(8'($urandom_range(32, 126)), ff);
          send_record(pick[33:0], 1'b0);
          send_byte(CHAR_NL, 1'b0);
        end
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_records.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
